FILE: design/distance_pid_speed_controller_top_assert.svh
// Assertion macros for the distance PID speed controller checker.
// Depends on nothing; included by the checker file.
`ifndef DISTANCE_PID_SPEED_CONTROLLER_TOP_ASSERT_SVH
`define DISTANCE_PID_SPEED_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpsc: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpsc: next-cycle property failed");

`endif

FILE: design/dpsc_pkg.sv
// Shared constants, datapath operation codes and controller/datapath structs
// for the distance PID speed controller. No dependencies.
package dpsc_pkg;

    // Parameter defaults.
    localparam int POS_WIDTH_DEF = 24;
    localparam int SUM_WIDTH_DEF = 48;

    // Fixed field widths.
    localparam int COORD_W    = 24;
    localparam int GAIN_W     = 32;
    localparam int RATE_W     = 10;
    localparam int LIM_W      = 23;
    localparam int DIST_W     = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Square root: one result bit per step over a 50-bit radicand.
    localparam int SQRT_STEPS = 25;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_TOL   = 3'd7;

    // Datapath operation codes.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [OP_W-1:0] OP_ABS    = 4'd2;
    localparam logic [OP_W-1:0] OP_SQX    = 4'd3;
    localparam logic [OP_W-1:0] OP_SQY    = 4'd4;
    localparam logic [OP_W-1:0] OP_RADD   = 4'd5;
    localparam logic [OP_W-1:0] OP_SQRT   = 4'd6;
    localparam logic [OP_W-1:0] OP_DIST   = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_P  = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_IL = 4'd9;
    localparam logic [OP_W-1:0] OP_MUL_IH = 4'd10;
    localparam logic [OP_W-1:0] OP_MUL_DL = 4'd11;
    localparam logic [OP_W-1:0] OP_MUL_DH = 4'd12;
    localparam logic [OP_W-1:0] OP_TERM_D = 4'd13;
    localparam logic [OP_W-1:0] OP_SUM    = 4'd14;
    localparam logic [OP_W-1:0] OP_OUT    = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_last;
    } t_dp_sts;

endpackage

FILE: design/dpsc_ctrl.sv
// Sequencing state machine of the distance PID speed controller.
// Depends on dpsc_pkg; drives the datapath through t_dp_cmd.
module dpsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    output logic               o_stall,
    output logic               o_valid,
    output dpsc_pkg::t_dp_cmd  o_cmd,
    input  dpsc_pkg::t_dp_sts  i_sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ABS   = 4'd1;
    localparam logic [3:0] S_SQX   = 4'd2;
    localparam logic [3:0] S_SQY   = 4'd3;
    localparam logic [3:0] S_RADD  = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIST  = 4'd6;
    localparam logic [3:0] S_MP    = 4'd7;
    localparam logic [3:0] S_MIL   = 4'd8;
    localparam logic [3:0] S_MIH   = 4'd9;
    localparam logic [3:0] S_MDL   = 4'd10;
    localparam logic [3:0] S_MDH   = 4'd11;
    localparam logic [3:0] S_TD    = 4'd12;
    localparam logic [3:0] S_SUM   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_load_out;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = dpsc_pkg::OP_NONE;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = dpsc_pkg::OP_LOAD;
                    n_state  = S_ABS;
                end
            end
            S_ABS: begin
                o_cmd.op = dpsc_pkg::OP_ABS;
                n_state  = S_SQX;
            end
            S_SQX: begin
                o_cmd.op = dpsc_pkg::OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = dpsc_pkg::OP_SQY;
                n_state  = S_RADD;
            end
            S_RADD: begin
                o_cmd.op = dpsc_pkg::OP_RADD;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = dpsc_pkg::OP_SQRT;
                if (i_sts.sqrt_last) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.op = dpsc_pkg::OP_DIST;
                n_state  = S_MP;
            end
            S_MP: begin
                o_cmd.op = dpsc_pkg::OP_MUL_P;
                n_state  = S_MIL;
            end
            S_MIL: begin
                o_cmd.op = dpsc_pkg::OP_MUL_IL;
                n_state  = S_MIH;
            end
            S_MIH: begin
                o_cmd.op = dpsc_pkg::OP_MUL_IH;
                n_state  = S_MDL;
            end
            S_MDL: begin
                o_cmd.op = dpsc_pkg::OP_MUL_DL;
                n_state  = S_MDH;
            end
            S_MDH: begin
                o_cmd.op = dpsc_pkg::OP_MUL_DH;
                n_state  = S_TD;
            end
            S_TD: begin
                o_cmd.op = dpsc_pkg::OP_TERM_D;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = dpsc_pkg::OP_SUM;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // Hold while the previous result is still waiting downstream.
                if (!(r_out_valid && i_stall)) begin
                    o_cmd.op   = dpsc_pkg::OP_OUT;
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && i_stall) || w_load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: design/dpsc_datapath.sv
// Datapath of the distance PID speed controller: configuration registers,
// distance square root, PID terms on a shared 32x32 multiplier, output register.
// Depends on dpsc_pkg; commanded by dpsc_ctrl.
module dpsc_datapath #(
    parameter int POS_WIDTH = dpsc_pkg::POS_WIDTH_DEF,
    parameter int SUM_WIDTH = dpsc_pkg::SUM_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dpsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [POS_WIDTH-1:0]         i_pos_x,
    input  logic signed [POS_WIDTH-1:0]         i_pos_y,
    input  dpsc_pkg::t_dp_cmd                   i_cmd,
    output dpsc_pkg::t_dp_sts                   o_sts,
    output logic signed [dpsc_pkg::COORD_W-1:0] o_velocity,
    output logic [dpsc_pkg::DIST_W-1:0]         o_distance,
    output logic                                o_reached
);

    localparam int DW      = (POS_WIDTH > dpsc_pkg::COORD_W) ? POS_WIDTH + 1
                                                             : dpsc_pkg::COORD_W + 1;
    localparam int DIST_W  = dpsc_pkg::DIST_W;
    localparam int RAD_W   = 2 * dpsc_pkg::SQRT_STEPS;
    localparam int ROOT_W  = dpsc_pkg::SQRT_STEPS;
    localparam int REM_W   = ROOT_W + 1;
    localparam int TRY_W   = REM_W + 2;
    localparam int DRATE_W = DIST_W + dpsc_pkg::RATE_W;
    localparam int TERM_W  = 41;
    localparam int VSUM_W  = TERM_W + 2;
    localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [dpsc_pkg::SQRT_CNT_W-1:0] SQRT_LAST =
        dpsc_pkg::SQRT_CNT_W'(dpsc_pkg::SQRT_STEPS - 1);

    // (hi:lo product of a 64-bit operand and a gain) >> 24, capped at 2^40.
    function automatic logic [TERM_W-1:0] f_cap(input logic [63:0] hi,
                                                 input logic [63:0] lo);
        logic [TERM_W-1:0] sum;
        sum = {1'b0, hi[31:0], 8'b0} + {1'b0, lo[63:24]};
        if (|hi[63:32]) begin
            f_cap = TERM_CAP;
        end else if (sum > TERM_CAP) begin
            f_cap = TERM_CAP;
        end else begin
            f_cap = sum;
        end
    endfunction

    // Configuration registers.
    logic signed [dpsc_pkg::COORD_W-1:0] r_tgt_x, r_tgt_y;
    logic [dpsc_pkg::GAIN_W-1:0]         r_gp, r_gi, r_gd;
    logic [dpsc_pkg::RATE_W-1:0]         r_rate;
    logic [dpsc_pkg::LIM_W-1:0]          r_lim, r_tol;

    // Controller state kept across items.
    logic [DIST_W-1:0]    r_last;
    logic [SUM_WIDTH-1:0] r_esum;
    logic                 r_seen;

    // Per-item working registers.
    logic signed [POS_WIDTH-1:0] r_px, r_py;
    logic [DIST_W-1:0]           r_ax, r_ay;
    logic                        r_far;
    logic [63:0]                 r_prod, r_lo;
    logic [RAD_W-1:0]            r_rad;
    logic [REM_W-1:0]            r_rem;
    logic [ROOT_W-1:0]           r_root;
    logic [dpsc_pkg::SQRT_CNT_W-1:0] r_cnt;
    logic [DIST_W-1:0]           r_dist;
    logic [DIST_W-1:0]           r_dmag;
    logic                        r_dneg;
    logic [DRATE_W-1:0]          r_drate;
    logic [TERM_W-1:0]           r_pterm, r_iterm, r_dterm;
    logic signed [VSUM_W-1:0]    r_v;

    // Output register.
    logic signed [dpsc_pkg::COORD_W-1:0] r_vel;
    logic [DIST_W-1:0]                   r_dout;
    logic                                r_reach;

    // Differences to the target and their magnitudes.
    logic signed [DW-1:0] w_dx, w_dy;
    logic [DW-1:0]        w_ux, w_uy, w_mx, w_my;
    logic                 w_far;

    assign w_dx  = DW'(r_tgt_x) - DW'(r_px);
    assign w_dy  = DW'(r_tgt_y) - DW'(r_py);
    assign w_ux  = w_dx;
    assign w_uy  = w_dy;
    assign w_mx  = w_ux[DW-1] ? (~w_ux + DW'(1)) : w_ux;
    assign w_my  = w_uy[DW-1] ? (~w_uy + DW'(1)) : w_uy;
    assign w_far = (|w_mx[DW-1:DIST_W]) || (|w_my[DW-1:DIST_W]);

    // Shared multiplier.
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mul, w_esum64;

    assign w_esum64 = 64'(r_esum);

    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        case (i_cmd.op)
            dpsc_pkg::OP_SQX: begin
                w_ma = 32'(r_ax);
                w_mb = 32'(r_ax);
            end
            dpsc_pkg::OP_SQY: begin
                w_ma = 32'(r_ay);
                w_mb = 32'(r_ay);
            end
            dpsc_pkg::OP_MUL_P: begin
                w_ma = 32'(r_dist);
                w_mb = r_gp;
            end
            dpsc_pkg::OP_MUL_IL: begin
                w_ma = w_esum64[31:0];
                w_mb = r_gi;
            end
            dpsc_pkg::OP_MUL_IH: begin
                w_ma = w_esum64[63:32];
                w_mb = r_gi;
            end
            dpsc_pkg::OP_MUL_DL: begin
                w_ma = 32'(r_drate);
                w_mb = r_gd;
            end
            dpsc_pkg::OP_MUL_DH: begin
                w_ma = 32'(r_drate[DRATE_W-1:32]);
                w_mb = r_gd;
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    assign w_mul = {32'd0, w_ma} * {32'd0, w_mb};

    // One restoring square root step: two radicand bits in, one root bit out.
    logic [TRY_W-1:0] w_rem_sh, w_trial, w_rem_sub;
    logic             w_ge;

    assign w_rem_sh  = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_ge      = (w_rem_sh >= w_trial);
    assign w_rem_sub = w_rem_sh - w_trial;

    // Distance, derivative change and saturating integral sum.
    logic [DIST_W-1:0]    w_dist;
    logic [SUM_WIDTH:0]   w_esum_add;

    assign w_dist     = (r_far || r_root[ROOT_W-1]) ? DIST_MAX : r_root[DIST_W-1:0];
    assign w_esum_add = {1'b0, r_esum} + (SUM_WIDTH + 1)'(w_dist);

    // PID sum and symmetric clamp.
    logic signed [VSUM_W-1:0] w_psum, w_dterm, w_lim, w_vclamp;

    assign w_psum  = $signed(VSUM_W'(r_pterm)) + $signed(VSUM_W'(r_iterm));
    assign w_dterm = $signed(VSUM_W'(r_dterm));
    assign w_lim   = $signed(VSUM_W'(r_lim));

    always_comb begin
        if (r_v > w_lim) begin
            w_vclamp = w_lim;
        end else if (r_v < -w_lim) begin
            w_vclamp = -w_lim;
        end else begin
            w_vclamp = r_v;
        end
    end

    // Configuration registers and the state that persists across items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x <= 24'sd8192;
            r_tgt_y <= 24'sd0;
            r_gp    <= 32'd168;
            r_gi    <= 32'd1678;
            r_gd    <= 32'd16777;
            r_rate  <= 10'd100;
            r_lim   <= 23'd1229;
            r_tol   <= 23'd410;
            r_last  <= '0;
            r_esum  <= '0;
            r_seen  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dpsc_pkg::REG_TARGET_X:    r_tgt_x <= i_cfg_data[23:0];
                    dpsc_pkg::REG_TARGET_Y:    r_tgt_y <= i_cfg_data[23:0];
                    dpsc_pkg::REG_GAIN_P:      r_gp    <= i_cfg_data;
                    dpsc_pkg::REG_GAIN_I:      r_gi    <= i_cfg_data;
                    dpsc_pkg::REG_GAIN_D:      r_gd    <= i_cfg_data;
                    dpsc_pkg::REG_SAMPLE_RATE: r_rate  <= i_cfg_data[9:0];
                    dpsc_pkg::REG_SPEED_LIMIT: r_lim   <= i_cfg_data[22:0];
                    dpsc_pkg::REG_REACH_TOL:   r_tol   <= i_cfg_data[22:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == dpsc_pkg::OP_DIST) begin
                r_last <= w_dist;
                r_seen <= 1'b1;
                r_esum <= w_esum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}}
                                                : w_esum_add[SUM_WIDTH-1:0];
            end
        end
    end

    // Square root step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.op == dpsc_pkg::OP_RADD) begin
            r_cnt <= '0;
        end else if (i_cmd.op == dpsc_pkg::OP_SQRT) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_sts.sqrt_last = (r_cnt == SQRT_LAST);

    // Working registers, no reset.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            dpsc_pkg::OP_LOAD: begin
                r_px <= i_pos_x;
                r_py <= i_pos_y;
            end
            dpsc_pkg::OP_ABS: begin
                r_ax  <= w_mx[DIST_W-1:0];
                r_ay  <= w_my[DIST_W-1:0];
                r_far <= w_far;
            end
            dpsc_pkg::OP_SQX: begin
                r_prod <= w_mul;
            end
            dpsc_pkg::OP_SQY: begin
                r_rad  <= r_prod[RAD_W-1:0];
                r_prod <= w_mul;
            end
            dpsc_pkg::OP_RADD: begin
                r_rad  <= r_rad + r_prod[RAD_W-1:0];
                r_rem  <= '0;
                r_root <= '0;
            end
            dpsc_pkg::OP_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= w_ge ? w_rem_sub[REM_W-1:0] : w_rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], w_ge};
            end
            dpsc_pkg::OP_DIST: begin
                r_dist <= w_dist;
                // The first sample has no previous distance: zero change.
                if (!r_seen) begin
                    r_dmag <= '0;
                    r_dneg <= 1'b0;
                end else if (w_dist >= r_last) begin
                    r_dmag <= w_dist - r_last;
                    r_dneg <= 1'b0;
                end else begin
                    r_dmag <= r_last - w_dist;
                    r_dneg <= 1'b1;
                end
            end
            dpsc_pkg::OP_MUL_P: begin
                r_prod  <= w_mul;
                r_drate <= DRATE_W'(r_dmag) * DRATE_W'(r_rate);
            end
            dpsc_pkg::OP_MUL_IL: begin
                r_pterm <= f_cap(64'd0, r_prod);
                r_prod  <= w_mul;
            end
            dpsc_pkg::OP_MUL_IH: begin
                r_lo   <= r_prod;
                r_prod <= w_mul;
            end
            dpsc_pkg::OP_MUL_DL: begin
                r_iterm <= f_cap(r_prod, r_lo);
                r_prod  <= w_mul;
            end
            dpsc_pkg::OP_MUL_DH: begin
                r_lo   <= r_prod;
                r_prod <= w_mul;
            end
            dpsc_pkg::OP_TERM_D: begin
                r_dterm <= f_cap(r_prod, r_lo);
            end
            dpsc_pkg::OP_SUM: begin
                r_v <= r_dneg ? (w_psum - w_dterm) : (w_psum + w_dterm);
            end
            dpsc_pkg::OP_OUT: begin
                r_vel   <= w_vclamp[dpsc_pkg::COORD_W-1:0];
                r_dout  <= r_dist;
                r_reach <= (r_dist < DIST_W'(r_tol));
            end
            default: begin
            end
        endcase
    end

    assign o_velocity = r_vel;
    assign o_distance = r_dout;
    assign o_reached  = r_reach;

endmodule

FILE: design/distance_pid_speed_controller_top.sv
// Top level of the distance PID speed controller.
// Depends on dpsc_pkg, dpsc_ctrl and dpsc_datapath.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_pos_x, i_pos_y
//   result   out        o_valid / i_stall  o_velocity, o_distance, o_reached
//   config   in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// A request passes through the absolute differences, squares, bit-serial square
// root, distance and P, I and D products on the shared 32x32 multiplier before
// its result appears at o_valid. A new request waits until the previous one
// leaves its last step. Reset is synchronous and active low; it restores the
// register defaults and clears the integral sum and derivative history. A
// stalled result is held in the output register and the next request may be
// accepted meanwhile; it waits in its last step until the output register frees.
module distance_pid_speed_controller_top #(
    parameter int POS_WIDTH = dpsc_pkg::POS_WIDTH_DEF,
    parameter int SUM_WIDTH = dpsc_pkg::SUM_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dpsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dpsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [POS_WIDTH-1:0]         i_pos_x,
    input  logic signed [POS_WIDTH-1:0]         i_pos_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dpsc_pkg::COORD_W-1:0] o_velocity,
    output logic [dpsc_pkg::DIST_W-1:0]         o_distance,
    output logic                                o_reached
);

    // The controller steps the datapath one operation per cycle unless the output
    // is stalled; the only feedback it needs is the end of the square root iteration.
    dpsc_pkg::t_dp_cmd w_cmd;
    dpsc_pkg::t_dp_sts w_sts;

    dpsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // The datapath holds the configuration registers, the integral sum and the
    // previous distance, along with the result register seen on the ports.
    dpsc_datapath #(
        .POS_WIDTH (POS_WIDTH),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_velocity (o_velocity),
        .o_distance (o_distance),
        .o_reached  (o_reached)
    );

endmodule

FILE: design/dpsc_checker.sv
// Port-level checker for the distance PID speed controller, bound to the top.
// Depends on distance_pid_speed_controller_top_assert.svh and dpsc_pkg.
`include "distance_pid_speed_controller_top_assert.svh"

module dpsc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [dpsc_pkg::COORD_W-1:0] o_velocity,
    input logic [dpsc_pkg::DIST_W-1:0]         o_distance,
    input logic                                o_reached
);

    // A stalled result stays offered.
    `DPSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // A stalled result keeps its payload.
    `DPSC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_velocity) && $stable(o_distance) && $stable(o_reached))

    // Once a request is taken, the block is busy in the following cycle.
    `DPSC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // A result never appears right after its request is taken.
    `DPSC_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_valid && !o_stall, !$rose(o_valid))

endmodule

bind distance_pid_speed_controller_top dpsc_checker u_dpsc_checker (.*);
